// File: design/assert_macros.svh
// Shared assertion macros for the top-k table checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/topk_pkg.sv
package topk_pkg;

    // opcodes (s_tuser[0])
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes (m_tuser)
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOW        = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NAME_LIMIT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX  = 3'd4;

    // field widths
    localparam int NAME_FIELD_W  = 16;
    localparam int SCORE_W       = 32;
    localparam int INDEX_FIELD_W = 4;
    localparam int COUNT_FIELD_W = 4;

    // tdata layout, same on both sides
    localparam int NAME_LSB  = 0;
    localparam int SCORE_LSB = NAME_LSB + NAME_FIELD_W;
    localparam int TAIL_LSB  = SCORE_LSB + SCORE_W;
    localparam int TDATA_W   = 56;

endpackage

// File: design/top_k_sorted_score_table_unit.sv
// Sequence: an add scans the valid slots, then walks up from the tail shifting lower
//   scores down until its slot is found; a rejected add ends after the scan; a remove
//   reads from the index to the last valid slot, pulling each up; a bad index skips the table.
// Throughput: one request at a time; the next is taken once the result is registered.
//   Time is set by the single-port table memory walked by one compare/shift sequencer.
// Reset (rst_n, async, active low) empties the table and clears the handshake; memory kept.
module top_k_sorted_score_table_unit #(
    parameter int MAX_ENTRIES = 10,
    parameter int NAME_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [15:0] name_id, [47:16] score, [51:48] entry_index, [55:52] zero
    input  logic [topk_pkg::TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [0:0]                   s_tuser,
    // result channel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] removed_name, [47:16] removed_score, [51:48] entry_count, [55:52] zero
    output logic [topk_pkg::TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [topk_pkg::STATUS_W-1:0] m_tuser
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int WORD_W = NAME_BITS + topk_pkg::SCORE_W;
    localparam int SW     = topk_pkg::SCORE_W;
    localparam int NFW    = topk_pkg::NAME_FIELD_W;
    localparam int IFW    = topk_pkg::INDEX_FIELD_W;
    localparam int CFW    = topk_pkg::COUNT_FIELD_W;

    localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(MAX_ENTRIES - 1);
    localparam logic [CNT_W-1:0] HALF_C = CNT_W'(MAX_ENTRIES / 2);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CHK = 3'd2;
    localparam logic [2:0] S_INS_RD   = 3'd3;
    localparam logic [2:0] S_INS_CHK  = 3'd4;
    localparam logic [2:0] S_REM_RD   = 3'd5;
    localparam logic [2:0] S_REM_WR   = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    // table memory: {name, score} per slot, slot 0 highest score
    logic [WORD_W-1:0] table_mem [MAX_ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // request and working registers
    logic [NAME_BITS-1:0] name_reg, name_next;
    logic [SW-1:0]        score_reg, score_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     same_reg, same_next;
    logic                 low_reg, low_next;
    logic [topk_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [NAME_BITS-1:0] rem_name_reg, rem_name_next;
    logic [SW-1:0]        rem_score_reg, rem_score_next;

    // result register
    logic [topk_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [NFW-1:0]       out_name_reg, out_name_next;
    logic [SW-1:0]        out_score_reg, out_score_next;
    logic [CFW-1:0]       out_count_reg, out_count_next;

    // request field decode
    logic [NFW-1:0]           in_name;
    logic [SW-1:0]            in_score;
    logic [IFW-1:0]           in_index;
    logic [NAME_BITS+NFW-1:0] in_name_ext;
    logic [NAME_BITS-1:0]     name_in;
    logic [CNT_W+IFW-1:0]     idx_wide;
    logic [CNT_W+IFW-1:0]     cnt_wide;

    // helpers
    logic [NAME_BITS-1:0]     rd_name;
    logic [SW-1:0]            rd_score;
    logic [NAME_BITS+NFW-1:0] rem_name_ext;
    logic [CNT_W+CFW-1:0]     count_ext;
    logic [CNT_W-1:0]         ptr_inc;
    logic [CNT_W-1:0]         ptr_dec;
    logic [CNT_W-1:0]         grown_count;
    logic [CNT_W-1:0]         same_v;
    logic                     low_v;
    logic                     name_hit;

    assign in_name     = s_tdata[topk_pkg::NAME_LSB +: NFW];
    assign in_score    = s_tdata[topk_pkg::SCORE_LSB +: SW];
    assign in_index    = s_tdata[topk_pkg::TAIL_LSB +: IFW];
    assign in_name_ext = {{NAME_BITS{1'b0}}, in_name};
    assign name_in     = in_name_ext[NAME_BITS-1:0];
    assign idx_wide    = {{CNT_W{1'b0}}, in_index};
    assign cnt_wide    = {{IFW{1'b0}}, count_reg};

    assign rd_name      = rd_data_reg[WORD_W-1 -: NAME_BITS];
    assign rd_score     = rd_data_reg[SW-1:0];
    assign rem_name_ext = {{NFW{1'b0}}, rem_name_reg};
    assign count_ext    = {{CFW{1'b0}}, count_next};
    assign ptr_inc      = ptr_reg + ONE_C;
    assign ptr_dec      = ptr_reg - ONE_C;
    assign grown_count  = (count_reg == MAX_C) ? MAX_C : count_reg + ONE_C;

    // scan compare unit: name match and score threshold for the scanned slot
    assign name_hit = (rd_name == name_reg);
    assign same_v   = same_reg + {{(CNT_W-1){1'b0}}, name_hit};
    assign low_v    = low_reg
                    | ((ptr_reg == LAST_C) && (count_reg == MAX_C)
                       && ($signed(score_reg) <= $signed(rd_score)));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(topk_pkg::TDATA_W - topk_pkg::TAIL_LSB - CFW){1'b0}},
                       out_count_reg, out_score_reg, out_name_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        m_valid_next    = m_valid_reg;
        name_next       = name_reg;
        score_next      = score_reg;
        idx_next        = idx_reg;
        ptr_next        = ptr_reg;
        same_next       = same_reg;
        low_next        = low_reg;
        status_next     = status_reg;
        rem_name_next   = rem_name_reg;
        rem_score_next  = rem_score_reg;
        out_status_next = out_status_reg;
        out_name_next   = out_name_reg;
        out_score_next  = out_score_reg;
        out_count_next  = out_count_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = ptr_reg[IDX_W-1:0];
        wr_data         = {name_reg, score_reg};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    name_next      = name_in;
                    score_next     = in_score;
                    rem_name_next  = '0;
                    rem_score_next = '0;
                    ptr_next       = '0;
                    same_next      = '0;
                    low_next       = 1'b0;
                    if (s_tuser[0] == topk_pkg::OP_ADD)
                    begin
                        state_next = (count_reg == '0) ? S_INS_RD : S_SCAN_RD;
                    end
                    else if (idx_wide >= cnt_wide)
                    begin
                        status_next = topk_pkg::ST_BAD_INDEX;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_wide[CNT_W-1:0];
                        ptr_next   = idx_wide[CNT_W-1:0];
                        state_next = S_REM_RD;
                    end
                end
            end

            // name census over valid slots; lowest score checked on a full table
            S_SCAN_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                same_next = same_v;
                low_next  = low_v;
                if (ptr_inc < count_reg)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SCAN_RD;
                end
                else if (low_v)
                begin
                    status_next = topk_pkg::ST_LOW;
                    state_next  = S_DONE;
                end
                else if (same_v >= HALF_C)
                begin
                    status_next = topk_pkg::ST_NAME_LIMIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    // start at the new tail; on a full table the lowest slot is overwritten
                    ptr_next   = (count_reg == MAX_C) ? LAST_C : count_reg;
                    state_next = S_INS_RD;
                end
            end

            // insertion walk: shift lower scores down one slot until the spot is found
            S_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    wr_en       = 1'b1;
                    count_next  = grown_count;
                    status_next = topk_pkg::ST_INSERTED;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_dec[IDX_W-1:0];
                    state_next = S_INS_CHK;
                end
            end

            S_INS_CHK:
            begin
                wr_en = 1'b1;
                if ($signed(score_reg) > $signed(rd_score))
                begin
                    wr_data    = rd_data_reg;
                    ptr_next   = ptr_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next  = grown_count;
                    status_next = topk_pkg::ST_INSERTED;
                    state_next  = S_DONE;
                end
            end

            // removal: capture the slot, then pull the rest up one place
            S_REM_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_REM_WR;
            end

            S_REM_WR:
            begin
                if (ptr_reg == idx_reg)
                begin
                    rem_name_next  = rd_name;
                    rem_score_next = rd_score;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_dec[IDX_W-1:0];
                    wr_data = rd_data_reg;
                end
                if (ptr_inc < count_reg)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_REM_RD;
                end
                else
                begin
                    count_next  = count_reg - ONE_C;
                    status_next = topk_pkg::ST_REMOVED;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_status_next = status_reg;
                    out_name_next   = rem_name_ext[NFW-1:0];
                    out_score_next  = rem_score_reg;
                    out_count_next  = count_ext[CFW-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        name_reg       <= name_next;
        score_reg      <= score_next;
        idx_reg        <= idx_next;
        ptr_reg        <= ptr_next;
        same_reg       <= same_next;
        low_reg        <= low_next;
        status_reg     <= status_next;
        rem_name_reg   <= rem_name_next;
        rem_score_reg  <= rem_score_next;
        out_status_reg <= out_status_next;
        out_name_reg   <= out_name_next;
        out_score_reg  <= out_score_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

endmodule

// File: design/topk_checker.sv
`include "assert_macros.svh"

module topk_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [topk_pkg::TDATA_W-1:0]  m_tdata,
    input logic [topk_pkg::STATUS_W-1:0] m_tuser
);

    // result stalled by the sink holds its content
    `ASSERT_CLK(a_result_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // one request in flight: taking a request drops ready next cycle
    `ASSERT_CLK(a_busy_after_req, clk, rst_n, s_tvalid && s_tready |=> !s_tready, "ready stayed high after a request")

    // only a removal reports a name and score
    `ASSERT_CLK(a_removed_zero, clk, rst_n, m_tvalid && (m_tuser != topk_pkg::ST_REMOVED) |-> (m_tdata[topk_pkg::TAIL_LSB-1:0] == '0), "non-removal result carries a removed entry")

    // no result is presented right after reset
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid, "result valid after reset")

endmodule

bind top_k_sorted_score_table_unit topk_checker u_topk_checker (.*);

// File: tb/top_k_sorted_score_table_unit_tb.sv
localparam int TABLE_SLOTS = 10;

// One result as the block reports it
typedef struct packed {
    logic [topk_pkg::STATUS_W-1:0]      status;
    logic [topk_pkg::NAME_FIELD_W-1:0]  name;
    logic signed [topk_pkg::SCORE_W-1:0] score;
    logic [topk_pkg::COUNT_FIELD_W-1:0] count;
} table_result_t;

// Shadow copy of the score table plus the results still owed by the block
class score_table_scoreboard;
    logic [topk_pkg::NAME_FIELD_W-1:0]   slot_name [TABLE_SLOTS];
    logic signed [topk_pkg::SCORE_W-1:0] slot_score [TABLE_SLOTS];
    int unsigned fill;
    table_result_t owed[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_seen [5];

    function new();
        fill = 0;
        mismatches = 0;
        checked = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // Apply one accepted request to the shadow table and queue its result
    function void note_request(logic op, logic [15:0] name, logic signed [31:0] score,
                               logic [3:0] idx);
        table_result_t res;
        int unsigned same;
        int unsigned n;
        int unsigned j;
        res = '0;
        if (op == topk_pkg::OP_ADD)
        begin
            same = 0;
            for (int k = 0; k < fill; k++)
                if (slot_name[k] == name)
                    same++;
            // score check on a full table wins over the name check
            if (fill >= TABLE_SLOTS && score <= slot_score[TABLE_SLOTS-1])
                res.status = topk_pkg::ST_LOW;
            else if (same >= TABLE_SLOTS / 2)
                res.status = topk_pkg::ST_NAME_LIMIT;
            else
            begin
                // full table: the last slot is simply overwritten (lowest drops out)
                n = (fill < TABLE_SLOTS) ? fill + 1 : TABLE_SLOTS;
                j = n - 1;
                while (j > 0 && score > slot_score[j-1])
                begin
                    slot_name[j]  = slot_name[j-1];
                    slot_score[j] = slot_score[j-1];
                    j--;
                end
                slot_name[j]  = name;
                slot_score[j] = score;
                fill = n;
                res.status = topk_pkg::ST_INSERTED;
            end
        end
        else if (idx >= fill)
        begin
            res.status = topk_pkg::ST_BAD_INDEX;
        end
        else
        begin
            res.name  = slot_name[idx];
            res.score = slot_score[idx];
            for (int k = idx; k + 1 < fill; k++)
            begin
                slot_name[k]  = slot_name[k+1];
                slot_score[k] = slot_score[k+1];
            end
            fill--;
            res.status = topk_pkg::ST_REMOVED;
        end
        res.count = fill[3:0];
        status_seen[res.status]++;
        owed.push_back(res);
    endfunction

    function void check_result(table_result_t got);
        table_result_t want;
        if (owed.size() == 0)
        begin
            $display("%0t: result with no request outstanding: status %0d name %h score %0d count %0d",
                     $time, got.status, got.name, got.score, got.count);
            mismatches++;
            return;
        end
        want = owed.pop_front();
        checked++;
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
            mismatches++;
        end
        if (got.name !== want.name)
        begin
            $display("%0t: removed_name mismatch: expected %h, got %h", $time, want.name, got.name);
            mismatches++;
        end
        if (got.score !== want.score)
        begin
            $display("%0t: removed_score mismatch: expected %0d, got %0d",
                     $time, want.score, got.score);
            mismatches++;
        end
        if (got.count !== want.count)
        begin
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, want.count, got.count);
            mismatches++;
        end
    endfunction
endclass

module top_k_sorted_score_table_unit_tb;

    // Run limit: ~660 requests, each through its full sequence in the block, long sender
    // gaps and receiver stalls at 86 percent; taken several times over.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 160;

    logic clk = 1'b0;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [topk_pkg::TDATA_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [topk_pkg::TDATA_W-1:0] m_tdata;
    logic [topk_pkg::STATUS_W-1:0] m_tuser;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned requests_sent = 0;

    score_table_scoreboard sb;

    top_k_sorted_score_table_unit #(
        .MAX_ENTRIES(TABLE_SLOTS),
        .NAME_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure, redrawn every cycle
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Every accepted result is checked against the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result('{status: m_tuser,
                              name:   m_tdata[topk_pkg::NAME_LSB +: topk_pkg::NAME_FIELD_W],
                              score:  m_tdata[topk_pkg::SCORE_LSB +: topk_pkg::SCORE_W],
                              count:  m_tdata[topk_pkg::TAIL_LSB +: topk_pkg::COUNT_FIELD_W]});
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still owed",
                     $time, cycles, sb.owed.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present one request, starting and ending at a falling edge. tvalid stays
    // high into the next request unless the sender takes a gap.
    task automatic send_request(logic op, logic [15:0] name, logic [31:0] score,
                                logic [3:0] idx);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, idx, score, name};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, name, score, idx);
        requests_sent++;
        @(negedge clk);
    endtask

    // Random request shaped to keep the table busy: a small name pool so the
    // per-name limit bites, clustered scores for ties, mostly valid indexes.
    task automatic send_random_request(int unsigned add_pct);
        logic op;
        logic [15:0] name;
        logic [31:0] score;
        logic [3:0] idx;
        int unsigned pick;
        op = ($urandom_range(0, 99) < add_pct) ? topk_pkg::OP_ADD : topk_pkg::OP_REMOVE;
        name = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(1, 3)) : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50)
            score = 32'($urandom_range(0, 40)) - 32'd20;
        else if (pick < 90)
            score = $urandom;
        else
            score = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
        if (op == topk_pkg::OP_REMOVE && sb.fill > 0 && $urandom_range(0, 99) < 80)
            idx = 4'($urandom_range(0, sb.fill - 1));
        else
            idx = 4'($urandom_range(0, 15));
        send_request(op, name, score, idx);
    endtask

    initial
    begin
        int unsigned add_pct;
        sb = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = topk_pkg::OP_ADD;
        m_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, no idling
        // remove on an empty table
        send_request(topk_pkg::OP_REMOVE, 16'h0000, 32'h0, 4'd0);
        // extremes of name and score; tie at 0 goes after the earlier entry
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'h7fff_ffff, 4'hf);
        send_request(topk_pkg::OP_ADD, 16'h0000, 32'h8000_0000, 4'h0);
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'd0, 4'h5);
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'd0, 4'ha);
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'd100, 4'h0);
        send_request(topk_pkg::OP_ADD, 16'hffff, -32'sd5, 4'h0);
        // name already holds half the table
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'd7, 4'h0);
        // fill the table
        send_request(topk_pkg::OP_ADD, 16'h0001, 32'd50, 4'h0);
        send_request(topk_pkg::OP_ADD, 16'h0002, 32'd50, 4'h0);
        send_request(topk_pkg::OP_ADD, 16'h0003, -32'sd1, 4'h0);
        send_request(topk_pkg::OP_ADD, 16'h0004, 32'd2, 4'h0);
        // full table: score equal to the lowest is too low
        send_request(topk_pkg::OP_ADD, 16'h0005, 32'h8000_0000, 4'h0);
        // full table: lowest entry drops out silently
        send_request(topk_pkg::OP_ADD, 16'h0005, 32'd1, 4'h0);
        // full table: name limit counts the entry that would drop out
        send_request(topk_pkg::OP_ADD, 16'hffff, 32'd1000, 4'h0);
        // tie with the top score on a full table
        send_request(topk_pkg::OP_ADD, 16'h0007, 32'h7fff_ffff, 4'h0);
        // removes: out of range, last, first, index equal to count, middle
        send_request(topk_pkg::OP_REMOVE, 16'hffff, 32'hffff_ffff, 4'hf);
        send_request(topk_pkg::OP_REMOVE, 16'h0000, 32'h0, 4'd9);
        send_request(topk_pkg::OP_REMOVE, 16'h0000, 32'h0, 4'd0);
        send_request(topk_pkg::OP_REMOVE, 16'h0000, 32'h0, 4'd8);
        send_request(topk_pkg::OP_REMOVE, 16'h0000, 32'h0, 4'd3);

        // Random part over four idling phases
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 86;
                end
                default:
                begin
                    src_idle_pct = 11;
                    sink_stall_pct = 11;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // alternate fill and drain stretches so the table sweeps empty to full
                add_pct = ((n / 40) % 2 == 0) ? 70 : 35;
                send_random_request(add_pct);
            end
        end
        s_tvalid <= 1'b0;

        while (sb.owed.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, %0d mismatches.",
                 requests_sent, sb.checked, sb.mismatches);
        $display("Outcomes: inserted %0d, too low %0d, name limit %0d, removed %0d, bad index %0d.",
                 sb.status_seen[topk_pkg::ST_INSERTED], sb.status_seen[topk_pkg::ST_LOW],
                 sb.status_seen[topk_pkg::ST_NAME_LIMIT], sb.status_seen[topk_pkg::ST_REMOVED],
                 sb.status_seen[topk_pkg::ST_BAD_INDEX]);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/topk_pkg.sv
design/top_k_sorted_score_table_unit.sv
design/topk_checker.sv
tb/top_k_sorted_score_table_unit_tb.sv
